// ===== rtl/strs_pkg.sv =====
package strs_pkg;

    localparam int ELEMENTS    = 64;
    localparam int IDX_W       = $clog2(ELEMENTS);
    localparam int LEN_W       = $clog2(ELEMENTS + 1);
    localparam int DATA_W      = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_SET,
        CMD_QUERY,
        CMD_BAD
    } cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [IDX_W-1:0]  a;
        logic [IDX_W-1:0]  b;
        logic [DATA_W-1:0] value;
    } job_t;

endpackage

// ===== rtl/strs_ram.sv =====
module strs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/strs_front.sv =====
module strs_front
    import strs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [LEN_W-1:0]  cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_operation,
    input  logic [IDX_W-1:0]  s_index,
    input  logic [DATA_W-1:0] s_new_value,
    input  logic [IDX_W-1:0]  s_range_low,
    input  logic [IDX_W-1:0]  s_range_high,
    input  logic              q_full,
    output logic              q_push,
    output job_t              q_job
);

    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic             set_ok;
    logic             range_bad;

    always_comb begin
        len_next = len_reg;
        if (cfg_we) begin
            if (cfg_wdata == '0) begin
                len_next = LEN_W'(1);
            end else if (cfg_wdata > LEN_W'(ELEMENTS)) begin
                len_next = LEN_W'(ELEMENTS);
            end else begin
                len_next = cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= LEN_W'(ELEMENTS);
        end else begin
            len_reg <= len_next;
        end
    end

    assign s_ready   = !q_full;
    assign set_ok    = LEN_W'(s_index) < len_reg;
    assign range_bad = (s_range_low > s_range_high) || (LEN_W'(s_range_high) >= len_reg);

    // out-of-range sets are dropped here
    assign q_push = s_valid && s_ready && (s_operation || set_ok);

    always_comb begin
        q_job.value = s_new_value;
        if (!s_operation) begin
            q_job.cmd = CMD_SET;
            q_job.a   = s_index;
            q_job.b   = s_index;
        end else begin
            q_job.cmd = range_bad ? CMD_BAD : CMD_QUERY;
            q_job.a   = s_range_low;
            q_job.b   = s_range_high;
        end
    end

endmodule

// ===== rtl/strs_fifo.sv =====
module strs_fifo
    import strs_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic empty,
    output job_t head_job
);

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg;
    logic [QPTR_W-1:0] rptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full     = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign head_job = slot_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= (wptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= (rptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            count_reg <= count_reg + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn) !(push && full))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn) !(pop && empty))
        else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of bounds");

endmodule

// ===== rtl/strs_back.sv =====
module strs_back
    import strs_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     q_empty,
    input  job_t                     q_job,
    output logic                     q_pop,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_sum,
    output logic                     m_bad_range
);

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    addr_reg, addr_next;
    logic [IDX_W-1:0]    hi_reg, hi_next;
    logic                last_reg, last_next;
    logic [DATA_W-1:0]   acc_reg, acc_next;
    logic [ELEMENTS-1:0] leaf_valid_reg;
    logic                rd_ok_reg;
    logic                m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]   m_sum_reg, m_sum_next;
    logic                m_bad_reg, m_bad_next;
    logic                ram_we;
    logic [IDX_W-1:0]    ram_raddr;
    logic [DATA_W-1:0]   ram_rdata;
    logic [DATA_W-1:0]   leaf;

    strs_ram #(.WIDTH(DATA_W), .DEPTH(ELEMENTS)) u_leaves (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (q_job.a),
        .wdata (q_job.value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // leaves never written read as zero
    assign leaf = rd_ok_reg ? ram_rdata : '0;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (!q_empty && q_job.cmd == CMD_QUERY && !m_valid_reg) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (last_reg) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        q_pop        = 1'b0;
        ram_we       = 1'b0;
        ram_raddr    = addr_reg;
        addr_next    = addr_reg;
        hi_next      = hi_reg;
        last_next    = last_reg;
        acc_next     = acc_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_sum_next   = m_sum_reg;
        m_bad_next   = m_bad_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    unique case (q_job.cmd)
                        CMD_SET: begin
                            q_pop  = 1'b1;
                            ram_we = 1'b1;
                        end
                        CMD_BAD: begin
                            if (!m_valid_reg) begin
                                q_pop        = 1'b1;
                                m_valid_next = 1'b1;
                                m_sum_next   = '0;
                                m_bad_next   = 1'b1;
                            end
                        end
                        CMD_QUERY: begin
                            if (!m_valid_reg) begin
                                q_pop     = 1'b1;
                                ram_raddr = q_job.a;
                                addr_next = q_job.a + 1'b1;
                                hi_next   = q_job.b;
                                last_next = q_job.a == q_job.b;
                                acc_next  = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                acc_next = acc_reg + leaf;
                if (last_reg) begin
                    m_valid_next = 1'b1;
                    m_sum_next   = acc_reg + leaf;
                    m_bad_next   = 1'b0;
                end else begin
                    addr_next = addr_reg + 1'b1;
                    last_next = addr_reg == hi_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        addr_reg  <= addr_next;
        hi_reg    <= hi_next;
        last_reg  <= last_next;
        acc_reg   <= acc_next;
        m_sum_reg <= m_sum_next;
        m_bad_reg <= m_bad_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            leaf_valid_reg <= '0;
            rd_ok_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            rd_ok_reg   <= leaf_valid_reg[ram_raddr];
            if (ram_we) begin
                leaf_valid_reg[q_job.a] <= 1'b1;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_sum       = m_sum_reg;
    assign m_bad_range = m_bad_reg;

    a_scan_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> !m_valid_reg)
        else $error("scan running while result pending");
    a_no_pop_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> !q_pop)
        else $error("queue popped during scan");
    a_scan_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN && last_reg |=> m_valid_reg && state_reg == ST_IDLE)
        else $error("scan end without result");

endmodule

// ===== rtl/segment_tree_range_sum.sv =====
// channel   | handshake          | payload
// s_ (in)   | s_valid / s_ready  | s_operation s_index s_new_value s_range_low s_range_high
// m_ (out)  | m_valid / m_ready  | m_sum m_bad_range
// cfg       | cfg_we             | cfg_wdata (length in use)
//
// a set is written to the leaf memory as it leaves the queue; dropped sets never enter it
// a good query reads its range one leaf per cycle through the single read port
// of the leaf memory; a bad query returns a zero sum with m_bad_range set
// reset is synchronous and clears every leaf at once through per-leaf valid bits
// a two-item queue keeps s_ready up until two items wait behind a scan or a result held by m_ready
module segment_tree_range_sum
    import strs_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [LEN_W-1:0]         cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_operation,
    input  logic [IDX_W-1:0]         s_index,
    input  logic signed [DATA_W-1:0] s_new_value,
    input  logic [IDX_W-1:0]         s_range_low,
    input  logic [IDX_W-1:0]         s_range_high,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_sum,
    output logic                     m_bad_range
);

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    job_t push_job;
    job_t head_job;

    strs_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_index      (s_index),
        .s_new_value  (s_new_value),
        .s_range_low  (s_range_low),
        .s_range_high (s_range_high),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_job        (push_job)
    );

    strs_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head_job (head_job)
    );

    strs_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_empty     (q_empty),
        .q_job       (head_job),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_sum       (m_sum),
        .m_bad_range (m_bad_range)
    );

endmodule
